@@ design/scf_pkg.sv @@
// Shared types for the surface curvature pipeline.
package scf_pkg;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SINGULAR = 2'd1,
    STAT_COMPLEX  = 2'd2,
    STAT_SAT      = 2'd3
  } scf_status_t;

endpackage

@@ design/scf_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, with a sideband word.
module scf_sqrt #(
  parameter int RW     = 162,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [RW-1:0]     rad,
  input  logic [SIDE_W-1:0] side,
  output logic              out_vld,
  output logic [RW/2-1:0]   root,
  output logic [SIDE_W-1:0] side_o
);

  localparam int SW = RW / 2;
  localparam int MW = SW + 2;

  logic [RW-1:0]     rad_r  [0:SW];
  logic [MW-1:0]     rem_r  [0:SW];
  logic [SW-1:0]     root_r [0:SW];
  logic [SIDE_W-1:0] side_r [0:SW];
  logic [SW:0]       vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= rad;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= side;
    end
  end

  for (genvar k = 1; k <= SW; k++) begin : g_stage
    logic [MW+1:0] trial;
    logic [MW+1:0] sub;
    logic [MW+2:0] diff;
    logic          take;

    // bring down the next two radicand bits, try 4*root+1
    assign trial = {rem_r[k-1], rad_r[k-1][RW-1:RW-2]};
    assign sub   = (MW+2)'({root_r[k-1], 2'b01});
    assign diff  = {1'b0, trial} - {1'b0, sub};
    assign take  = !diff[MW+2];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_r[k-1] << 2;
        rem_r[k]  <= take ? diff[MW-1:0] : trial[MW-1:0];
        root_r[k] <= {root_r[k-1][SW-2:0], take};
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_vld = vld_r[SW];
  assign root    = root_r[SW];
  assign side_o  = side_r[SW];

endmodule

@@ design/scf_rdiv.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage, with overflow flag.
module scf_rdiv #(
  parameter int NW = 85,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  input  logic          neg,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic          neg_o
);

  localparam int CW = NW + QW;

  logic [CW-1:0] rem_r [0:QW];
  logic [NW-1:0] den_r [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic [QW:0]   ovf_r;
  logic [QW:0]   neg_r;

  // quotient needs more than QW bits: flag it, the result gets clamped
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= CW'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= ({{QW{1'b0}}, num} >= {den, {QW{1'b0}}});
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int SH = QW - k;
    logic [CW-1:0] dsh;
    logic [CW:0]   diff;

    assign dsh  = {{QW{1'b0}}, den_r[k-1]} << SH;
    assign diff = {1'b0, rem_r[k-1]} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= diff[CW] ? rem_r[k-1] : diff[CW-1:0];
        q_r[k]   <= q_r[k-1] | ({{(QW-1){1'b0}}, ~diff[CW]} << SH);
        den_r[k] <= den_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign quo   = q_r[QW];
  assign ovf   = ovf_r[QW];
  assign neg_o = neg_r[QW];

endmodule

@@ design/surface_curvature_from_forms.sv @@
// Top level: shape operator curvatures from first and second fundamental forms.
//
//  channel | ports                                 | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, in_first_form_*,  | input word
//          | in_second_form_*                      |
//  out     | out_valid, out_stall, out_*_curvature,| result word
//          | out_status                            |
//
// One word per cycle in and out while no stall holds the pipeline. The latency is set by
// the square root (one bit per stage) and the dividers
// (one quotient bit per stage) in series.
// Reset is synchronous and clears only the valid bits of the stages.
// A stall on out while out_valid is high freezes the whole pipeline and holds the output
// word; in_stall is raised combinationally in that cycle.
module surface_curvature_from_forms
  import scf_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_first_form_11,
  input  logic signed [DATA_WIDTH-1:0] in_first_form_12,
  input  logic signed [DATA_WIDTH-1:0] in_first_form_21,
  input  logic signed [DATA_WIDTH-1:0] in_first_form_22,
  input  logic signed [DATA_WIDTH-1:0] in_second_form_11,
  input  logic signed [DATA_WIDTH-1:0] in_second_form_12,
  input  logic signed [DATA_WIDTH-1:0] in_second_form_21,
  input  logic signed [DATA_WIDTH-1:0] in_second_form_22,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_gauss_curvature,
  output logic signed [DATA_WIDTH-1:0] out_mean_curvature,
  output logic signed [DATA_WIDTH-1:0] out_major_curvature,
  output logic signed [DATA_WIDTH-1:0] out_minor_curvature,
  output logic [1:0]                   out_status
);

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int PW     = 2 * W;
  localparam int MW     = PW + 1;
  localparam int XW     = PW + 2;
  localparam int HW     = (MW + 1) / 2;
  localparam int SQ     = 2 * MW;
  localparam int DSW    = 2 * MW + 3;
  localparam int RW     = 2 * F + 2 * MW + 2;
  localparam int SW     = RW / 2;
  localparam int EW     = SW + 2;
  localparam int NW     = EW + 1;
  localparam int SIDE_W = XW + MW + 5 + 2 * NW;

  typedef struct packed {
    logic [MW-1:0] am;
    logic          aneg;
    logic          dz;
    logic          cplx;
    logic          gneg;
    logic          hneg;
    logic [NW-1:0] gn;
    logic [NW-1:0] hn;
  } carry_t;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- S1: products
  logic signed [PW-1:0] prod_r [0:7];
  logic [4:0]           vs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= '0;
    end else if (en) begin
      vs_r <= {vs_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= in_first_form_11 * in_first_form_22;
      prod_r[1] <= in_first_form_12 * in_first_form_21;
      prod_r[2] <= in_second_form_11 * in_second_form_22;
      prod_r[3] <= in_second_form_12 * in_second_form_21;
      prod_r[4] <= in_first_form_22 * in_second_form_11;
      prod_r[5] <= in_first_form_12 * in_second_form_21;
      prod_r[6] <= in_first_form_21 * in_second_form_12;
      prod_r[7] <= in_first_form_11 * in_second_form_22;
    end
  end

  // ---------------- S2: determinants and trace of adj(A)*B
  logic signed [PW:0]   da_r, db_r;
  logic signed [XW-1:0] t_r2;

  always_ff @(posedge clk) begin
    if (en) begin
      da_r <= (PW+1)'(prod_r[0]) - (PW+1)'(prod_r[1]);
      db_r <= (PW+1)'(prod_r[2]) - (PW+1)'(prod_r[3]);
      t_r2 <= XW'(prod_r[4]) - XW'(prod_r[5]) - XW'(prod_r[6]) + XW'(prod_r[7]);
    end
  end

  // ---------------- S3: magnitudes
  logic [MW-1:0]        am_r3, bm_r3, tm_r3;
  logic                 aneg_r3, bneg_r3, tneg_r3, dz_r3;
  logic signed [XW-1:0] t_r3;

  always_ff @(posedge clk) begin
    if (en) begin
      am_r3   <= da_r[PW] ? MW'(-da_r) : MW'(da_r);
      bm_r3   <= db_r[PW] ? MW'(-db_r) : MW'(db_r);
      tm_r3   <= t_r2[XW-1] ? MW'(-t_r2) : MW'(t_r2);
      aneg_r3 <= da_r[PW];
      bneg_r3 <= db_r[PW];
      tneg_r3 <= t_r2[XW-1];
      dz_r3   <= (da_r == '0);
      t_r3    <= t_r2;
    end
  end

  // ---------------- S4: partial products for T^2 and dA*dB, plain numerators
  logic [HW-1:0] tl, th, al, ah, bl, bh;
  assign tl = tm_r3[HW-1:0];
  assign th = HW'(tm_r3[MW-1:HW]);
  assign al = am_r3[HW-1:0];
  assign ah = HW'(am_r3[MW-1:HW]);
  assign bl = bm_r3[HW-1:0];
  assign bh = HW'(bm_r3[MW-1:HW]);

  logic [2*HW-1:0]      pp_tll_r, pp_tlh_r, pp_thh_r;
  logic [2*HW-1:0]      pp_all_r, pp_alh_r, pp_ahl_r, pp_ahh_r;
  logic signed [XW-1:0] t_r4;
  logic [MW-1:0]        am_r4;
  logic                 aneg_r4, dz_r4, sgn_r4, gneg_r4, hneg_r4;
  logic [NW-1:0]        gn_r4, hn_r4;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_tll_r <= tl * tl;
      pp_tlh_r <= tl * th;
      pp_thh_r <= th * th;
      pp_all_r <= al * bl;
      pp_alh_r <= al * bh;
      pp_ahl_r <= ah * bl;
      pp_ahh_r <= ah * bh;
      t_r4     <= t_r3;
      am_r4    <= am_r3;
      aneg_r4  <= aneg_r3;
      dz_r4    <= dz_r3;
      sgn_r4   <= aneg_r3 ^ bneg_r3;
      // round-half-away numerators: 2|n| + |m|
      gn_r4    <= (NW'(bm_r3) << (F + 1)) + NW'(am_r3);
      hn_r4    <= (NW'(tm_r3) << (F + 1)) + (NW'(am_r3) << 1);
      gneg_r4  <= bneg_r3 ^ aneg_r3;
      hneg_r4  <= tneg_r3 ^ aneg_r3;
    end
  end

  // ---------------- S5: sum partial products
  logic [SQ-1:0]        t2_r5, ab_r5;
  logic signed [XW-1:0] t_r5;
  logic [MW-1:0]        am_r5;
  logic                 aneg_r5, dz_r5, sgn_r5, gneg_r5, hneg_r5;
  logic [NW-1:0]        gn_r5, hn_r5;

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r5   <= (SQ'(pp_thh_r) << (2 * HW)) + (SQ'(pp_tlh_r) << (HW + 1)) + SQ'(pp_tll_r);
      ab_r5   <= (SQ'(pp_ahh_r) << (2 * HW)) + ((SQ'(pp_alh_r) + SQ'(pp_ahl_r)) << HW)
                 + SQ'(pp_all_r);
      t_r5    <= t_r4;
      am_r5   <= am_r4;
      aneg_r5 <= aneg_r4;
      dz_r5   <= dz_r4;
      sgn_r5  <= sgn_r4;
      gn_r5   <= gn_r4;
      hn_r5   <= hn_r4;
      gneg_r5 <= gneg_r4;
      hneg_r5 <= hneg_r4;
    end
  end

  // ---------------- discriminant, into the square root
  logic [DSW-1:0]    t2e, q4, disc;
  logic              cplx;
  logic [RW-1:0]     rad;
  logic [SIDE_W-1:0] sq_side, sq_side_o;
  logic [SW-1:0]     sq_root;
  logic              sq_vld;

  assign t2e  = DSW'(t2_r5);
  assign q4   = DSW'(ab_r5) << 2;
  assign disc = sgn_r5 ? t2e + q4 : t2e - q4;
  assign cplx = disc[DSW-1];
  assign rad  = cplx ? '0 : {disc[DSW-2:0], {(2 * F){1'b0}}};

  assign sq_side = {t_r5, am_r5, aneg_r5, dz_r5, cplx, gneg_r5, hneg_r5, gn_r5, hn_r5};

  scf_sqrt #(
    .RW     (RW),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vs_r[4]),
    .rad     (rad),
    .side    (sq_side),
    .out_vld (sq_vld),
    .root    (sq_root),
    .side_o  (sq_side_o)
  );

  logic [XW-1:0] sq_t;
  carry_t        sq_cr;

  assign {sq_t, sq_cr.am, sq_cr.aneg, sq_cr.dz, sq_cr.cplx, sq_cr.gneg, sq_cr.hneg,
          sq_cr.gn, sq_cr.hn} = sq_side_o;

  // ---------------- E1: T*2^F +/- s
  logic [EW-1:0] tf;
  logic [EW-1:0] n1_r, n2_r;
  carry_t        cr_e1, cr_e2;
  logic [2:0]    ve_r;

  assign tf = {{(EW - XW){sq_t[XW-1]}}, sq_t} << F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= '0;
    end else if (en) begin
      ve_r <= {ve_r[1:0], sq_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r  <= tf + EW'(sq_root);
      n2_r  <= tf - EW'(sq_root);
      cr_e1 <= sq_cr;
    end
  end

  // ---------------- E2: magnitudes of the eigen numerators
  logic [EW-1:0] m1_r, m2_r;
  logic          neg1_r2, neg2_r2;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r    <= n1_r[EW-1] ? -n1_r : n1_r;
      m2_r    <= n2_r[EW-1] ? -n2_r : n2_r;
      neg1_r2 <= n1_r[EW-1] ^ cr_e1.aneg;
      neg2_r2 <= n2_r[EW-1] ^ cr_e1.aneg;
      cr_e2   <= cr_e1;
    end
  end

  // ---------------- E3: divider operands
  logic [NW-1:0] gn_r3, hn_r3, e1n_r, e2n_r;
  logic [MW-1:0] am_e3;
  logic          gneg_e3, hneg_e3, neg1_e3, neg2_e3, dz_e3, cplx_e3;

  always_ff @(posedge clk) begin
    if (en) begin
      gn_r3   <= cr_e2.gn;
      hn_r3   <= cr_e2.hn;
      e1n_r   <= (NW'(m1_r) << 1) + (NW'(cr_e2.am) << 1);
      e2n_r   <= (NW'(m2_r) << 1) + (NW'(cr_e2.am) << 1);
      am_e3   <= cr_e2.am;
      gneg_e3 <= cr_e2.gneg;
      hneg_e3 <= cr_e2.hneg;
      neg1_e3 <= neg1_r2;
      neg2_e3 <= neg2_r2;
      dz_e3   <= cr_e2.dz;
      cplx_e3 <= cr_e2.cplx;
    end
  end

  logic [NW-1:0] den2, den4;
  assign den2 = NW'(am_e3) << 1;
  assign den4 = NW'(am_e3) << 2;

  logic [W-1:0] qk, qh, q1, q2;
  logic         ok, oh, o1, o2, nk, nh, n1s, n2s;

  scf_rdiv #(.NW(NW), .QW(W)) u_div_gauss (
    .clk (clk), .en (en), .num (gn_r3), .den (den2), .neg (gneg_e3),
    .quo (qk), .ovf (ok), .neg_o (nk)
  );

  scf_rdiv #(.NW(NW), .QW(W)) u_div_mean (
    .clk (clk), .en (en), .num (hn_r3), .den (den4), .neg (hneg_e3),
    .quo (qh), .ovf (oh), .neg_o (nh)
  );

  scf_rdiv #(.NW(NW), .QW(W)) u_div_eig1 (
    .clk (clk), .en (en), .num (e1n_r), .den (den4), .neg (neg1_e3),
    .quo (q1), .ovf (o1), .neg_o (n1s)
  );

  scf_rdiv #(.NW(NW), .QW(W)) u_div_eig2 (
    .clk (clk), .en (en), .num (e2n_r), .den (den4), .neg (neg2_e3),
    .quo (q2), .ovf (o2), .neg_o (n2s)
  );

  // flags ride alongside the dividers
  logic [W:0] dv_r, ddz_r, dcx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[W-1:0], ve_r[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ddz_r <= {ddz_r[W-1:0], dz_e3};
      dcx_r <= {dcx_r[W-1:0], cplx_e3};
    end
  end

  // ---------------- F1: sign, clamp, special cases
  function automatic logic [W:0] sat_fn(input logic [W-1:0] q, input logic ovf,
                                        input logic neg);
    logic [W-1:0] lim_p;
    logic [W-1:0] lim_n;
    logic [W:0]   res;
    lim_p = {1'b0, {(W - 1){1'b1}}};
    lim_n = {1'b1, {(W - 1){1'b0}}};
    if (!neg) begin
      res = (ovf || q > lim_p) ? {1'b1, lim_p} : {1'b0, q};
    end else begin
      res = (ovf || q > lim_n) ? {1'b1, lim_n} : {1'b0, -q};
    end
    return res;
  endfunction

  logic [W:0]   sk, sh, s1, s2;
  logic         any_sat;
  logic [W-1:0] k_r1, h_r1, l1_r1, l2_r1;
  scf_status_t  st_r1;
  logic [1:0]   vf_r;

  assign sk      = sat_fn(qk, ok, nk);
  assign sh      = sat_fn(qh, oh, nh);
  assign s1      = sat_fn(q1, o1, n1s);
  assign s2      = sat_fn(q2, o2, n2s);
  assign any_sat = sk[W] || sh[W] || (!dcx_r[W] && (s1[W] || s2[W]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
    end else if (en) begin
      vf_r <= {vf_r[0], dv_r[W]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ddz_r[W]) begin
        k_r1  <= '0;
        h_r1  <= '0;
        l1_r1 <= '0;
        l2_r1 <= '0;
        st_r1 <= STAT_SINGULAR;
      end else begin
        k_r1  <= sk[W-1:0];
        h_r1  <= sh[W-1:0];
        l1_r1 <= dcx_r[W] ? sh[W-1:0] : s1[W-1:0];
        l2_r1 <= dcx_r[W] ? sh[W-1:0] : s2[W-1:0];
        st_r1 <= any_sat ? STAT_SAT : (dcx_r[W] ? STAT_COMPLEX : STAT_OK);
      end
    end
  end

  // ---------------- F2: magnitudes for ordering
  logic [W-1:0] k_r2, h_r2, l1_r2, l2_r2, x1_r2, x2_r2;
  scf_status_t  st_r2;

  always_ff @(posedge clk) begin
    if (en) begin
      k_r2  <= k_r1;
      h_r2  <= h_r1;
      l1_r2 <= l1_r1;
      l2_r2 <= l2_r1;
      x1_r2 <= l1_r1[W-1] ? -l1_r1 : l1_r1;
      x2_r2 <= l2_r1[W-1] ? -l2_r1 : l2_r1;
      st_r2 <= st_r1;
    end
  end

  // ---------------- F3: order and output register
  logic         swap;
  logic         out_valid_r;
  logic [W-1:0] gauss_r, mean_r, major_r, minor_r;
  scf_status_t  status_r;

  // larger magnitude first, greater value on a tie
  assign swap = (x2_r2 > x1_r2) ||
                ((x2_r2 == x1_r2) && ($signed(l2_r2) > $signed(l1_r2)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vf_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gauss_r  <= k_r2;
      mean_r   <= h_r2;
      major_r  <= swap ? l2_r2 : l1_r2;
      minor_r  <= swap ? l1_r2 : l2_r2;
      status_r <= st_r2;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_gauss_curvature = gauss_r;
  assign out_mean_curvature  = mean_r;
  assign out_major_curvature = major_r;
  assign out_minor_curvature = minor_r;
  assign out_status          = status_r;

endmodule

@@ design/scf_checker.sv @@
// Port-level checks for the curvature pipeline, bound to the top level.
module scf_checker
  import scf_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DATA_WIDTH-1:0] out_gauss_curvature,
  input logic signed [DATA_WIDTH-1:0] out_mean_curvature,
  input logic signed [DATA_WIDTH-1:0] out_major_curvature,
  input logic signed [DATA_WIDTH-1:0] out_minor_curvature,
  input logic [1:0]                   out_status
);

  logic [DATA_WIDTH-1:0] mag_major, mag_minor;

  assign mag_major = out_major_curvature[DATA_WIDTH-1] ? -out_major_curvature
                                                       : out_major_curvature;
  assign mag_minor = out_minor_curvature[DATA_WIDTH-1] ? -out_minor_curvature
                                                       : out_minor_curvature;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_SINGULAR |->
      out_gauss_curvature == '0 && out_mean_curvature == '0 &&
      out_major_curvature == '0 && out_minor_curvature == '0)
    else $error("singular word carries nonzero curvature");

  a_complex_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_COMPLEX |->
      out_major_curvature == out_mean_curvature &&
      out_minor_curvature == out_mean_curvature)
    else $error("complex word does not report the half trace");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> mag_major >= mag_minor)
    else $error("major curvature smaller in magnitude than minor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_major_curvature) && $stable(out_status))
    else $error("stalled result word changed");

endmodule

bind surface_curvature_from_forms scf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_scf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_gauss_curvature (out_gauss_curvature),
  .out_mean_curvature  (out_mean_curvature),
  .out_major_curvature (out_major_curvature),
  .out_minor_curvature (out_minor_curvature),
  .out_status          (out_status)
);
